/* design/udp_relay_classifier_rate_limit_assert.svh */
`ifndef UDP_RELAY_CLASSIFIER_RATE_LIMIT_ASSERT_SVH
`define UDP_RELAY_CLASSIFIER_RATE_LIMIT_ASSERT_SVH

// implication checked on the same edge
`define URCRL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication checked on the next edge
`define URCRL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/urcrl_pkg.sv */
package urcrl_pkg;

   localparam int FIXED_PORT_COUNT = 3;

   localparam logic        FUNC_BYTE = 1'b0;
   localparam logic        FUNC_TICK = 1'b1;

   localparam logic [1:0]  VERDICT_PASS    = 2'd0;
   localparam logic [1:0]  VERDICT_BCAST   = 2'd1;
   localparam logic [1:0]  VERDICT_UNICAST = 2'd2;
   localparam logic [1:0]  VERDICT_DROP    = 2'd3;

   typedef enum logic [1:0] {
      CSR_RELAY_ENABLE,
      CSR_PORT_ENABLE_MASK,
      CSR_HOST_BROADCAST_IP,
      CSR_PACKETS_PER_SECOND
   } csr_index_type;

   localparam logic [15:0] PPS_RESET      = 16'd100;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [31:0] GUEST_NET      = 32'h0a0a0a00;
   localparam logic [31:0] GUEST_MASK     = 32'hffffff00;
   localparam logic [31:0] GUEST_BCAST    = 32'h0a0a0aff;
   localparam logic [31:0] ALL_ONES_IP    = 32'hffffffff;
   localparam logic [7:0]  MIN_LAST_POS   = 8'd41;
   localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
   localparam logic [15:0] MAX_UDP_LEN    = 16'd1508;
   localparam logic [10:0] MAX_PAYLOAD    = 11'd1500;

   typedef struct packed {
      logic [7:0]  byte_position;
      logic        dest_mac_all_ones;
      logic [15:0] ether_type;
      logic [3:0]  header_words;
      logic [7:0]  ip_protocol;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] udp_source_port;
      logic [15:0] udp_dest_port;
      logic [15:0] udp_length;
      logic        udp_header_seen;
   } frame_type;

   function automatic logic [15:0] fixed_port(input logic [1:0] idx);
      logic [15:0] port;
      case (idx)
         2'd0:    port = 16'd32770;
         2'd1:    port = 16'd32771;
         2'd2:    port = 16'd49171;
         default: port = 16'd0;
      endcase
      return port;
   endfunction

endpackage

/* design/udp_relay_classifier_rate_limit.sv */
// a frame's last byte is registered in the input stage, then in the result register, before its word shows on rsp_valid
// throughput: one input word per cycle, ticks and middle bytes included; a last byte
// waits in the input stage only while the previous result word is not yet accepted
// the rate is set by the single capture/decision stage between input and result registers
// reset (synchronous, active high) restores register defaults, clears capture state,
// the learned guest address, the window count and both valid stages
module udp_relay_classifier_rate_limit #(
   parameter int PORT_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_consumed,
   output logic [1:0]  rsp_port_index,
   output logic [15:0] rsp_relay_dest_port,
   output logic [31:0] rsp_relay_dest_ip,
   output logic [10:0] rsp_payload_length,
   output logic [31:0] rsp_learned_guest_ip,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import urcrl_pkg::*;

   localparam int NUM_PORTS =
      (PORT_COUNT < FIXED_PORT_COUNT) ? PORT_COUNT : FIXED_PORT_COUNT;

   localparam logic [7:0] POS_MAC_END  = 8'd6;
   localparam logic [7:0] POS_ETYPE_HI = 8'd12;
   localparam logic [7:0] POS_ETYPE_LO = 8'd13;
   localparam logic [7:0] POS_IHL      = 8'd14;
   localparam logic [7:0] POS_PROTO    = 8'd23;
   localparam logic [7:0] POS_SIP_LO   = 8'd26;
   localparam logic [7:0] POS_SIP_HI   = 8'd29;
   localparam logic [7:0] POS_DIP_LO   = 8'd30;
   localparam logic [7:0] POS_DIP_HI   = 8'd33;
   localparam logic [7:0] POS_MAX      = 8'd255;
   localparam logic [7:0] UDP_HDR_BYTES = 8'd8;

   localparam frame_type FRAME_CLEAR = '{
      byte_position:     8'd0,
      dest_mac_all_ones: 1'b1,
      ether_type:        16'd0,
      header_words:      4'd0,
      ip_protocol:       8'd0,
      source_ip:         32'd0,
      dest_ip:           32'd0,
      udp_source_port:   16'd0,
      udp_dest_port:     16'd0,
      udp_length:        16'd0,
      udp_header_seen:   1'b0
   };

   // configuration
   logic        relay_enable_ff;
   logic [2:0]  port_mask_ff;
   logic [31:0] host_bcast_ff;
   logic [15:0] pps_ff;

   // input stage
   logic        s1_valid_ff;
   logic        s1_func_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;

   // block state
   frame_type   frame_ff, frame_in, cap;
   logic [31:0] guest_ff, guest_in;
   logic [15:0] wc_ff, wc_in;

   // result stage
   logic        rsp_valid_ff;
   logic [1:0]  verdict_ff, verdict_in;
   logic        consumed_ff, consumed_in;
   logic [1:0]  pidx_ff, pidx_in;
   logic [15:0] dport_ff, dport_in;
   logic [31:0] dip_ff, dip_in;
   logic [10:0] plen_ff, plen_in;

   logic        is_tick, frame_end, out_free, advance;
   logic [3:0]  words;
   logic [7:0]  udp_base, udp_off;
   logic        in_udp;
   logic        checks_ok, bcast, ext, hit;
   logic [NUM_PORTS-1:0] dmatch, smatch;
   logic        d_found, s_found, found;
   logic [1:0]  d_idx, s_idx, idx;
   logic [15:0] plen_wide;

   assign is_tick   = (s1_func_ff == FUNC_TICK);
   assign frame_end = s1_valid_ff && !is_tick && s1_last_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && (!frame_end || out_free);
   assign req_ready = !s1_valid_ff || advance;

   // header capture for the byte in the input stage
   always_comb begin
      words    = (frame_ff.byte_position == POS_IHL) ? s1_byte_ff[3:0] : frame_ff.header_words;
      udp_base = POS_IHL + {2'b00, words, 2'b00};
      udp_off  = frame_ff.byte_position - udp_base;
      in_udp   = (frame_ff.byte_position >= udp_base) && (udp_off < UDP_HDR_BYTES);
      cap      = frame_ff;
      if (frame_ff.byte_position < POS_MAC_END && s1_byte_ff != 8'hff) begin
         cap.dest_mac_all_ones = 1'b0;
      end
      if (frame_ff.byte_position == POS_ETYPE_HI) cap.ether_type[15:8] = s1_byte_ff;
      if (frame_ff.byte_position == POS_ETYPE_LO) cap.ether_type[7:0] = s1_byte_ff;
      if (frame_ff.byte_position == POS_IHL) cap.header_words = s1_byte_ff[3:0];
      if (frame_ff.byte_position == POS_PROTO) cap.ip_protocol = s1_byte_ff;
      if (frame_ff.byte_position >= POS_SIP_LO && frame_ff.byte_position <= POS_SIP_HI) begin
         cap.source_ip = {frame_ff.source_ip[23:0], s1_byte_ff};
      end
      if (frame_ff.byte_position >= POS_DIP_LO && frame_ff.byte_position <= POS_DIP_HI) begin
         cap.dest_ip = {frame_ff.dest_ip[23:0], s1_byte_ff};
      end
      if (in_udp) begin
         case (udp_off[2:0])
            3'd0, 3'd1: cap.udp_source_port = {frame_ff.udp_source_port[7:0], s1_byte_ff};
            3'd2, 3'd3: cap.udp_dest_port = {frame_ff.udp_dest_port[7:0], s1_byte_ff};
            3'd4, 3'd5: cap.udp_length = {frame_ff.udp_length[7:0], s1_byte_ff};
            3'd7:       cap.udp_header_seen = 1'b1;
            default:    ;
         endcase
      end
      if (frame_ff.byte_position != POS_MAX) begin
         cap.byte_position = frame_ff.byte_position + 8'd1;
      end
   end

   // port lookup, destination before source, lowest index wins
   always_comb begin
      d_found = 1'b0;
      s_found = 1'b0;
      d_idx   = 2'd0;
      s_idx   = 2'd0;
      for (int i = 0; i < NUM_PORTS; i++) begin
         dmatch[i] = (cap.udp_dest_port == fixed_port(2'(i)));
         smatch[i] = (cap.udp_source_port == fixed_port(2'(i)));
      end
      for (int i = NUM_PORTS - 1; i >= 0; i--) begin
         if (dmatch[i]) begin
            d_found = 1'b1;
            d_idx   = 2'(i);
         end
         if (smatch[i]) begin
            s_found = 1'b1;
            s_idx   = 2'(i);
         end
      end
      found = d_found || s_found;
      idx   = d_found ? d_idx : s_idx;
   end

   // frame end decision
   always_comb begin
      checks_ok = relay_enable_ff && (frame_ff.byte_position >= MIN_LAST_POS) &&
                  (cap.ether_type == ETHERTYPE_IPV4) && (cap.ip_protocol == PROTO_UDP);
      bcast = cap.dest_mac_all_ones || (cap.dest_ip == ALL_ONES_IP) ||
              (cap.dest_ip == GUEST_BCAST);
      ext   = !bcast && ((cap.dest_ip & GUEST_MASK) != GUEST_NET);
      hit   = checks_ok && cap.udp_header_seen && found && (bcast || ext) && port_mask_ff[idx];
      plen_wide = cap.udp_length - UDP_HDR_LEN;

      guest_in    = guest_ff;
      wc_in       = wc_ff;
      verdict_in  = VERDICT_PASS;
      consumed_in = 1'b0;
      pidx_in     = 2'd0;
      dport_in    = 16'd0;
      dip_in      = 32'd0;
      plen_in     = 11'd0;

      if (checks_ok && ((cap.source_ip & GUEST_MASK) == GUEST_NET) &&
          (cap.source_ip != GUEST_BCAST)) begin
         guest_in = cap.source_ip;
      end
      if (hit) begin
         if (wc_ff >= pps_ff) begin
            verdict_in  = VERDICT_DROP;
            consumed_in = 1'b1;
            pidx_in     = idx;
         end else begin
            wc_in = wc_ff + 16'd1;
            // window slot is spent even when the length is bad
            if (cap.udp_length > UDP_HDR_LEN && cap.udp_length <= MAX_UDP_LEN) begin
               verdict_in  = bcast ? VERDICT_BCAST : VERDICT_UNICAST;
               consumed_in = ext;
               pidx_in     = idx;
               dport_in    = cap.udp_dest_port;
               dip_in      = bcast ? host_bcast_ff : cap.dest_ip;
               plen_in     = plen_wide[10:0];
            end
         end
      end

      frame_in = frame_end ? FRAME_CLEAR : cap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_enable_ff <= 1'b0;
         port_mask_ff    <= 3'd0;
         host_bcast_ff   <= 32'd0;
         pps_ff          <= PPS_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_RELAY_ENABLE:       relay_enable_ff <= csr_wdata[0];
            CSR_PORT_ENABLE_MASK:   port_mask_ff    <= csr_wdata[2:0];
            CSR_HOST_BROADCAST_IP:  host_bcast_ff   <= csr_wdata;
            CSR_PACKETS_PER_SECOND: pps_ff          <= csr_wdata[15:0];
            default:                ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_ready) begin
         s1_func_ff <= req_func;
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= FRAME_CLEAR;
         guest_ff <= 32'd0;
         wc_ff    <= 16'd0;
      end else if (advance) begin
         if (is_tick) begin
            wc_ff <= 16'd0;
         end else begin
            frame_ff <= frame_in;
            if (frame_end) begin
               guest_ff <= guest_in;
               wc_ff    <= wc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && frame_end) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && frame_end) begin
         verdict_ff  <= verdict_in;
         consumed_ff <= consumed_in;
         pidx_ff     <= pidx_in;
         dport_ff    <= dport_in;
         dip_ff      <= dip_in;
         plen_ff     <= plen_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_verdict          = verdict_ff;
   assign rsp_consumed         = consumed_ff;
   assign rsp_port_index       = pidx_ff;
   assign rsp_relay_dest_port  = dport_ff;
   assign rsp_relay_dest_ip    = dip_ff;
   assign rsp_payload_length   = plen_ff;
   assign rsp_learned_guest_ip = guest_ff;

endmodule

/* design/urcrl_checker.sv */
`include "udp_relay_classifier_rate_limit_assert.svh"

module urcrl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_verdict,
   input logic        rsp_consumed,
   input logic [1:0]  rsp_port_index,
   input logic [15:0] rsp_relay_dest_port,
   input logic [31:0] rsp_relay_dest_ip,
   input logic [10:0] rsp_payload_length
);
   import urcrl_pkg::*;

   // a stalled word keeps its verdict
   `URCRL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict), "result word changed while stalled")

   // pass-through words carry no relay target
   `URCRL_ASSERT_SAME(a_pass_empty, clock, reset, rsp_valid && rsp_verdict == VERDICT_PASS, !rsp_consumed && rsp_port_index == 2'd0 && rsp_relay_dest_port == 16'd0 && rsp_relay_dest_ip == 32'd0 && rsp_payload_length == 11'd0, "pass word carries relay fields")

   // a rate drop is consumed and keeps only the port index
   `URCRL_ASSERT_SAME(a_drop_fields, clock, reset, rsp_valid && rsp_verdict == VERDICT_DROP, rsp_consumed && rsp_relay_dest_port == 16'd0 && rsp_relay_dest_ip == 32'd0 && rsp_payload_length == 11'd0, "drop word has relay fields")

   // relayed words have a legal payload and consume only unicast
   `URCRL_ASSERT_SAME(a_relay_len, clock, reset, rsp_valid && (rsp_verdict == VERDICT_BCAST || rsp_verdict == VERDICT_UNICAST), rsp_payload_length != 11'd0 && rsp_payload_length <= MAX_PAYLOAD && rsp_consumed == (rsp_verdict == VERDICT_UNICAST) && rsp_port_index != 2'd3, "relayed word out of range")

endmodule

bind udp_relay_classifier_rate_limit urcrl_checker u_urcrl_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_verdict         (rsp_verdict),
   .rsp_consumed        (rsp_consumed),
   .rsp_port_index      (rsp_port_index),
   .rsp_relay_dest_port (rsp_relay_dest_port),
   .rsp_relay_dest_ip   (rsp_relay_dest_ip),
   .rsp_payload_length  (rsp_payload_length)
);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
   import urcrl_pkg::*;

   localparam int PORT_COUNT = 3;
   localparam logic [31:0] GUEST_A = 32'h0a0a0a07;
   localparam logic [31:0] OUTSIDE = 32'h08080808;

   typedef struct packed {
      logic       func;
      logic [7:0] data;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic        consumed;
      logic [1:0]  port_index;
      logic [15:0] relay_dest_port;
      logic [31:0] relay_dest_ip;
      logic [10:0] payload_length;
      logic [31:0] learned_guest_ip;
   } relay_verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_verdict;
   logic        rsp_consumed;
   logic [1:0]  rsp_port_index;
   logic [15:0] rsp_relay_dest_port;
   logic [31:0] rsp_relay_dest_ip;
   logic [10:0] rsp_payload_length;
   logic [31:0] rsp_learned_guest_ip;
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [31:0] csr_wdata = 32'd0;

   udp_relay_classifier_rate_limit #(.PORT_COUNT(PORT_COUNT)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_data_byte        (req_data_byte),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_verdict          (rsp_verdict),
      .rsp_consumed         (rsp_consumed),
      .rsp_port_index       (rsp_port_index),
      .rsp_relay_dest_port  (rsp_relay_dest_port),
      .rsp_relay_dest_ip    (rsp_relay_dest_ip),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_learned_guest_ip (rsp_learned_guest_ip),
      .csr_wen              (csr_wen),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   req_word_type      pending_words[$];
   relay_verdict_type expected_verdicts[$];

   int  error_count = 0;
   int  frames_checked = 0;
   int  words_queued = 0;
   int  ticks_sent = 0;
   int  verdict_hits[4] = '{0, 0, 0, 0};
   int  tick_odds = 0;
   bit  steady = 1'b0;

   // configuration copy
   logic        cfg_relay_en = 1'b0;
   logic [2:0]  cfg_port_mask = 3'd0;
   logic [31:0] cfg_bcast_ip = 32'd0;
   logic [15:0] cfg_pps = PPS_RESET;

   // frame capture copy
   logic [7:0]  cap_pos = 8'd0;
   logic        cap_mac_bcast = 1'b1;
   logic [15:0] cap_etype = 16'd0;
   logic [3:0]  cap_ihl = 4'd0;
   logic [7:0]  cap_proto = 8'd0;
   logic [31:0] cap_src_ip = 32'd0;
   logic [31:0] cap_dst_ip = 32'd0;
   logic [15:0] cap_sport = 16'd0;
   logic [15:0] cap_dport = 16'd0;
   logic [15:0] cap_ulen = 16'd0;
   logic        cap_udp_done = 1'b0;
   logic [31:0] learned_addr = 32'd0;
   logic [15:0] window_used = 16'd0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic [15:0] relay_port(input int k);
      logic [15:0] port;
      case (k)
         0:       port = 16'd32770;
         1:       port = 16'd32771;
         default: port = 16'd49171;
      endcase
      return port;
   endfunction

   function automatic int match_port(input logic [15:0] port);
      for (int i = 0; i < PORT_COUNT && i < FIXED_PORT_COUNT; i++)
         if (relay_port(i) == port) return i;
      return -1;
   endfunction

   function automatic void clear_capture();
      cap_pos = 8'd0;
      cap_mac_bcast = 1'b1;
      cap_etype = 16'd0;
      cap_ihl = 4'd0;
      cap_proto = 8'd0;
      cap_src_ip = 32'd0;
      cap_dst_ip = 32'd0;
      cap_sport = 16'd0;
      cap_dport = 16'd0;
      cap_ulen = 16'd0;
      cap_udp_done = 1'b0;
   endfunction

   // update the capture for one accepted word, queue the verdict at frame end
   function automatic void classify_word(input req_word_type w);
      int p, words, base, off, hit;
      logic len_ok, bcast, ext;
      relay_verdict_type r;
      if (w.func == FUNC_TICK) begin
         window_used = 16'd0;
         return;
      end
      p = cap_pos;
      len_ok = (cap_pos >= MIN_LAST_POS);
      words = (p == 14) ? int'(w.data[3:0]) : int'(cap_ihl);
      base = 14 + 4 * words;
      if (p < 6 && w.data != 8'hff) cap_mac_bcast = 1'b0;
      if (p == 12) cap_etype[15:8] = w.data;
      if (p == 13) cap_etype[7:0] = w.data;
      if (p == 14) cap_ihl = w.data[3:0];
      if (p == 23) cap_proto = w.data;
      if (p >= 26 && p <= 29) cap_src_ip = {cap_src_ip[23:0], w.data};
      if (p >= 30 && p <= 33) cap_dst_ip = {cap_dst_ip[23:0], w.data};
      if (p >= base && p < base + 8) begin
         off = p - base;
         if (off < 2) cap_sport = {cap_sport[7:0], w.data};
         else if (off < 4) cap_dport = {cap_dport[7:0], w.data};
         else if (off < 6) cap_ulen = {cap_ulen[7:0], w.data};
         else if (off == 7) cap_udp_done = 1'b1;
      end
      if (cap_pos != 8'hff) cap_pos = cap_pos + 8'd1;
      if (!w.last) return;

      r = '0;
      r.verdict = VERDICT_PASS;
      if (cfg_relay_en && len_ok && cap_etype == ETHERTYPE_IPV4 && cap_proto == PROTO_UDP) begin
         if ((cap_src_ip & GUEST_MASK) == GUEST_NET && cap_src_ip != GUEST_BCAST)
            learned_addr = cap_src_ip;
         bcast = cap_mac_bcast || cap_dst_ip == ALL_ONES_IP || cap_dst_ip == GUEST_BCAST;
         ext = !bcast && (cap_dst_ip & GUEST_MASK) != GUEST_NET;
         hit = match_port(cap_dport);
         if (hit < 0) hit = match_port(cap_sport);
         if (cap_udp_done && hit >= 0 && (bcast || ext) && cfg_port_mask[hit]) begin
            if (window_used >= cfg_pps) begin
               r.verdict = VERDICT_DROP;
               r.consumed = 1'b1;
               r.port_index = 2'(hit);
            end else begin
               window_used = window_used + 16'd1;
               if (cap_ulen > UDP_HDR_LEN && cap_ulen <= MAX_UDP_LEN) begin
                  r.verdict = bcast ? VERDICT_BCAST : VERDICT_UNICAST;
                  r.consumed = ext;
                  r.port_index = 2'(hit);
                  r.relay_dest_port = cap_dport;
                  r.relay_dest_ip = bcast ? cfg_bcast_ip : cap_dst_ip;
                  r.payload_length = 11'(cap_ulen - UDP_HDR_LEN);
               end
            end
         end
      end
      r.learned_guest_ip = learned_addr;
      expected_verdicts.push_back(r);
      clear_capture();
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) flag_mismatch(what, got, want);
   endtask

   // driver: one word presented at a time, held until accepted
   always @(posedge clock) begin : word_driver
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            w.func = req_func;
            w.data = req_data_byte;
            w.last = req_last_byte;
            classify_word(w);
         end
         if (!req_valid || req_ready) begin
            if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
               w = pending_words.pop_front();
               req_valid <= 1'b1;
               req_func <= w.func;
               req_data_byte <= w.data;
               req_last_byte <= w.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: each accepted result word against the oldest expectation
   always @(posedge clock) begin : verdict_monitor
      relay_verdict_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               flag_mismatch("unexpected result word, verdict", 32'(rsp_verdict), 32'd0);
            end else begin
               e = expected_verdicts.pop_front();
               frames_checked++;
               verdict_hits[e.verdict]++;
               check_field("verdict", 32'(rsp_verdict), 32'(e.verdict));
               check_field("consumed", 32'(rsp_consumed), 32'(e.consumed));
               check_field("port_index", 32'(rsp_port_index), 32'(e.port_index));
               check_field("relay_dest_port", 32'(rsp_relay_dest_port),
                           32'(e.relay_dest_port));
               check_field("relay_dest_ip", rsp_relay_dest_ip, e.relay_dest_ip);
               check_field("payload_length", 32'(rsp_payload_length),
                           32'(e.payload_length));
               check_field("learned_guest_ip", rsp_learned_guest_ip, e.learned_guest_ip);
            end
         end
         rsp_ready <= steady || $urandom_range(99) >= 33;
      end
   end

   task automatic push_word(input logic func, input logic [7:0] data, input logic last);
      req_word_type w;
      w.func = func;
      w.data = data;
      w.last = last;
      pending_words.push_back(w);
      words_queued++;
      if (func == FUNC_TICK) ticks_sent++;
   endtask

   // tick words carry junk in the ignored fields
   task automatic push_tick();
      push_word(FUNC_TICK, 8'($urandom), 1'($urandom));
   endtask

   task automatic push_frame(input logic [7:0] fb[], input int tick_at);
      for (int i = 0; i < fb.size(); i++) begin
         if (i == tick_at || (tick_odds > 0 && $urandom_range(tick_odds - 1) == 0))
            push_tick();
         push_word(FUNC_BYTE, fb[i], i == fb.size() - 1);
      end
   endtask

   task automatic build_udp_frame(input logic bcast_mac, input logic [31:0] src_ip,
                                  input logic [31:0] dst_ip, input logic [15:0] sport,
                                  input logic [15:0] dport, input logic [15:0] ulen,
                                  input logic [15:0] etype, input logic [7:0] proto,
                                  input logic [3:0] ihl, input int frame_bytes,
                                  input int tick_at);
      logic [7:0] fb[];
      int n, base;
      base = 14 + 4 * ihl;
      n = base + 8;
      if (n < 42) n = 42;
      if (frame_bytes > n) n = frame_bytes;
      fb = new[n];
      foreach (fb[i]) fb[i] = 8'($urandom);
      for (int i = 0; i < 6; i++)
         fb[i] = (bcast_mac || $urandom_range(3) == 0) ? 8'hff : 8'($urandom);
      if (!bcast_mac && fb[0] == 8'hff) fb[0] = 8'h02;
      fb[12] = etype[15:8];
      fb[13] = etype[7:0];
      fb[14] = {($urandom_range(7) == 0) ? 4'($urandom) : 4'h4, ihl};
      fb[23] = proto;
      for (int i = 0; i < 4; i++) begin
         fb[26 + i] = src_ip[31 - 8 * i -: 8];
         fb[30 + i] = dst_ip[31 - 8 * i -: 8];
      end
      // a header shorter than five words leaves the ip bytes in place as udp header
      if (ihl >= 4'd5) begin
         fb[base]     = sport[15:8];
         fb[base + 1] = sport[7:0];
         fb[base + 2] = dport[15:8];
         fb[base + 3] = dport[7:0];
         fb[base + 4] = ulen[15:8];
         fb[base + 5] = ulen[7:0];
      end
      if (frame_bytes < n) fb = new[frame_bytes](fb);
      push_frame(fb, tick_at);
   endtask

   function automatic logic [15:0] pick_port();
      logic [15:0] port;
      case ($urandom_range(4))
         0, 1, 2: port = relay_port($urandom_range(2));
         3:       port = 16'($urandom);
         default: port = relay_port($urandom_range(2)) + ($urandom_range(1) ? 16'd1 : -16'd1);
      endcase
      return port;
   endfunction

   task automatic queue_random_frame();
      logic [7:0] fb[];
      logic [31:0] src, dst;
      logic [15:0] ulen, etype;
      logic [7:0] proto;
      logic [3:0] ihl;
      int hdr, len, mode;
      mode = $urandom_range(99);
      if (mode < 8) begin
         fb = new[$urandom_range(1, 70)];
         foreach (fb[i]) fb[i] = 8'($urandom);
         push_frame(fb, -1);
         return;
      end
      src = ($urandom_range(9) < 7) ? (GUEST_NET | 32'($urandom_range(255))) : $urandom;
      case ($urandom_range(5))
         0:       dst = ALL_ONES_IP;
         1:       dst = GUEST_BCAST;
         2:       dst = GUEST_NET | 32'($urandom_range(254));
         default: dst = $urandom;
      endcase
      case ($urandom_range(9))
         0:       ulen = 16'($urandom_range(8));
         1:       ulen = 16'd9;
         2:       ulen = MAX_UDP_LEN;
         3:       ulen = MAX_UDP_LEN + 16'd1;
         4:       ulen = 16'($urandom);
         default: ulen = 16'(8 + $urandom_range(1, 1500));
      endcase
      etype = ($urandom_range(9) == 0) ? 16'($urandom) : ETHERTYPE_IPV4;
      proto = ($urandom_range(9) == 0) ? 8'($urandom) : PROTO_UDP;
      ihl = ($urandom_range(99) < 85) ? 4'd5 : 4'($urandom);
      hdr = 14 + 4 * ihl + 8;
      if (hdr < 42) hdr = 42;
      mode = $urandom_range(99);
      if (mode < 75) len = hdr + $urandom_range(12);
      else if (mode < 88) len = $urandom_range(1, hdr - 1);
      else if (mode < 98) len = 41 + $urandom_range(1);
      else len = $urandom_range(256, 320);
      build_udp_frame($urandom_range(3) == 0, src, dst, pick_port(), pick_port(), ulen,
                      etype, proto, ihl, len, -1);
   endtask

   // called only with nothing in flight
   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      case (idx)
         CSR_RELAY_ENABLE: begin
            csr_wdata <= {31'($urandom), value[0]};
            cfg_relay_en = value[0];
         end
         CSR_PORT_ENABLE_MASK: begin
            csr_wdata <= {29'($urandom), value[2:0]};
            cfg_port_mask = value[2:0];
         end
         CSR_HOST_BROADCAST_IP: begin
            csr_wdata <= value;
            cfg_bcast_ip = value;
         end
         default: begin
            csr_wdata <= {16'($urandom), value[15:0]};
            cfg_pps = value[15:0];
         end
      endcase
   endtask

   task automatic apply_settings(input logic en, input logic [2:0] mask,
                                 input logic [31:0] bip, input logic [15:0] pps);
      write_csr(CSR_RELAY_ENABLE, 32'(en));
      write_csr(CSR_PORT_ENABLE_MASK, 32'(mask));
      write_csr(CSR_HOST_BROADCAST_IP, bip);
      write_csr(CSR_PACKETS_PER_SECOND, 32'(pps));
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // ticks and trailing bytes give no word, so the wait runs on after the last result
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic random_settings(input int ph);
      logic [15:0] pps;
      logic [31:0] bip;
      case ($urandom_range(6))
         0:       pps = 16'd0;
         1:       pps = 16'd1;
         2:       pps = 16'd3;
         3:       pps = 16'hffff;
         4:       pps = 16'($urandom);
         default: pps = 16'($urandom_range(10));
      endcase
      case ($urandom_range(2))
         0:       bip = 32'd0;
         1:       bip = 32'hffffffff;
         default: bip = $urandom;
      endcase
      case (ph)
         0:       apply_settings(1'b1, 3'd7, 32'hffffffff, 16'hffff);
         1:       apply_settings(1'b1, 3'd7, 32'd0, 16'd0);
         2:       apply_settings(1'b1, 3'd0, bip, pps);
         default: apply_settings($urandom_range(5) != 0, 3'($urandom), bip, pps);
      endcase
   endtask

   initial begin : stimulus
      logic [7:0] one[];
      int random_items, phase_start, ph;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // relay off after reset: everything passes, nothing is learned
      build_udp_frame(1'b1, GUEST_A, ALL_ONES_IP, 16'd1, 16'd32770, 16'd40,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 50, -1);
      one = new[1];
      one[0] = 8'hff;
      push_frame(one, -1);
      push_tick();
      wait_drained();

      apply_settings(1'b1, 3'd7, 32'hc0a801ff, PPS_RESET);
      // broadcast mac, all-ones ip, guest broadcast ip
      build_udp_frame(1'b1, GUEST_A, 32'h0a0a0a09, 16'd1, 16'd32770, 16'd28,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      build_udp_frame(1'b0, GUEST_A, ALL_ONES_IP, 16'd2, 16'd32771, MAX_UDP_LEN,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 60, 20);
      build_udp_frame(1'b0, 32'h0a0a0a20, GUEST_BCAST, 16'd3, 16'd49171, 16'd9,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 44, -1);
      // external unicast matched on source port only
      build_udp_frame(1'b0, GUEST_A, OUTSIDE, 16'd32770, 16'd1234, 16'd100,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 46, -1);
      // internal unicast, no port match, wrong ethertype, wrong protocol
      build_udp_frame(1'b0, GUEST_A, 32'h0a0a0a03, 16'd5, 16'd32770, 16'd20,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      build_udp_frame(1'b0, GUEST_A, OUTSIDE, 16'd5, 16'd6, 16'd20,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      build_udp_frame(1'b1, GUEST_A, OUTSIDE, 16'd5, 16'd32770, 16'd20,
                      16'h86dd, PROTO_UDP, 4'd5, 42, -1);
      build_udp_frame(1'b1, GUEST_A, OUTSIDE, 16'd5, 16'd32770, 16'd20,
                      ETHERTYPE_IPV4, 8'd6, 4'd5, 42, -1);
      // one byte under the minimum length
      build_udp_frame(1'b1, 32'h0a0a0a30, OUTSIDE, 16'd5, 16'd32770, 16'd20,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 41, -1);
      // udp header past the end of the frame, still learns
      build_udp_frame(1'b1, 32'h0a0a0a14, OUTSIDE, 16'd5, 16'd32770, 16'd20,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'hf, 60, -1);
      build_udp_frame(1'b1, GUEST_A, OUTSIDE, 16'd5, 16'd32770, 16'd20,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd0, 42, -1);
      // payload length out of range
      build_udp_frame(1'b0, GUEST_A, OUTSIDE, 16'd5, 16'd49171, UDP_HDR_LEN,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      build_udp_frame(1'b0, GUEST_A, OUTSIDE, 16'd5, 16'd49171, MAX_UDP_LEN + 16'd1,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      build_udp_frame(1'b0, GUEST_A, OUTSIDE, 16'd5, 16'd49171, 16'd0,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      // guest broadcast as source is not learned; long frame saturates the position
      build_udp_frame(1'b0, GUEST_BCAST, OUTSIDE, 16'd5, 16'd32771, 16'd64,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 300, -1);
      wait_drained();

      // budget of two, then a new window
      apply_settings(1'b1, 3'd7, 32'hffffffff, 16'd2);
      for (int i = 0; i < 4; i++) begin
         if (i == 3) push_tick();
         build_udp_frame(1'b0, GUEST_A, OUTSIDE, 16'd5, relay_port(i % 3), 16'd30,
                         ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      end
      wait_drained();
      apply_settings(1'b1, 3'd1, 32'd0, 16'd0);
      build_udp_frame(1'b1, GUEST_A, OUTSIDE, 16'd5, 16'd32770, 16'd30,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      build_udp_frame(1'b1, GUEST_A, OUTSIDE, 16'd5, 16'd32771, 16'd30,
                      ETHERTYPE_IPV4, PROTO_UDP, 4'd5, 42, -1);
      wait_drained();

      random_items = 0;
      ph = 0;
      tick_odds = 80;
      while (random_items < 1000 || ph < 4) begin
         random_settings(ph);
         steady = (ph == 3);
         phase_start = words_queued;
         while (words_queued - phase_start < 250) begin
            @(negedge clock);
            if ($urandom_range(99) < 15) push_tick();
            queue_random_frame();
         end
         random_items += words_queued - phase_start;
         wait_drained();
         ph++;
      end
      steady = 1'b0;

      wait_drained();
      repeat (10) @(negedge clock);
      $display("covered %0d words, %0d ticks, %0d frames over %0d random phases",
               words_queued, ticks_sent, frames_checked, ph);
      $display("verdicts: pass %0d, broadcast %0d, unicast %0d, rate dropped %0d",
               verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3]);
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
